>>> design/bmm_pkg.sv
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types and constants for the bipartite maximum matching block.
// ----------------------------------------------------------------------------
package bmm_pkg;

   localparam int VERTICES = 16;
   // Rows and right vertices are indexed by a 4-bit field.
   localparam int SIDE_MAX = 16;
   localparam int SIDE_CAP = (VERTICES < SIDE_MAX) ? VERTICES : SIDE_MAX;
   localparam logic [4:0] SIDE_CAP_W  = 5'(SIDE_CAP);
   localparam logic [4:0] DEPTH_MAX_W = 5'(SIDE_MAX);
   localparam logic [4:0] ACTIVE_RESET = 5'd16;

   typedef struct packed {
      logic [3:0]  left_vertex;
      logic [15:0] neighbours;
      logic        last_row;
   } req_type;

   typedef struct packed {
      logic [3:0] right_vertex;
      logic [3:0] owner;
      logic       is_matched;
      logic [4:0] matching_size;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic begin_match;
      logic init_try;
      logic step;
      logic commit;
      logic next_u;
      logic emit_init;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic dead_end;
      logic free_hit;
      logic depth_one;
      logic last_u;
      logic last_emit;
      logic out_free;
   } dp_status_type;

endpackage

>>> design/bipartite_max_matching_top.sv
// ----------------------------------------------------------------------------
// bipartite_max_matching_top
// Kuhn augmenting-path maximum matching over a loaded bipartite graph.
// ----------------------------------------------------------------------------
// Rows are taken while idle; the row with the last mark starts the matching.
// Each left vertex then passes a try state, one search step per stack push, pop
// or free right vertex found, one commit per frame on the path, and a next state.
// Results then leave one per cycle for n right vertices unless stalled.
// Synchronous active-high reset clears control, matching state and sets the
// vertex count to 16; stored rows are undefined until loaded.
module bipartite_max_matching_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bmm_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bmm_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [4:0]        csr_data
);

   bmm_pkg::dp_cmd_type    cmd;
   bmm_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   bmm_controller u_ctl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_row (req_data.last_row),
      .status       (status),
      .req_stall    (req_stall),
      .cmd          (cmd)
   );

   bmm_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> design/bmm_controller.sv
// ----------------------------------------------------------------------------
// bmm_controller
// Sequencer for row loading, augmenting-path search, path commit and emit.
// ----------------------------------------------------------------------------
module bmm_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last_row,
   input  bmm_pkg::dp_status_type status,
   output logic                   req_stall,
   output bmm_pkg::dp_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_TRY    = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;
   localparam logic [2:0] ST_COMMIT = 3'd3;
   localparam logic [2:0] ST_NEXT   = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last_row) begin
                  cmd.begin_match = 1'b1;
                  state_in        = ST_TRY;
               end
            end
         end
         ST_TRY: begin
            cmd.init_try = 1'b1;
            state_in     = ST_SEARCH;
         end
         ST_SEARCH: begin
            cmd.step = 1'b1;
            if (status.dead_end) begin
               if (status.depth_one) begin
                  state_in = ST_NEXT;
               end
            end else if (status.free_hit) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // Pair one frame per cycle, top down.
            cmd.commit = 1'b1;
            if (status.depth_one) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (status.last_u) begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               cmd.next_u = 1'b1;
               state_in   = ST_TRY;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_emit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/bmm_datapath.sv
// ----------------------------------------------------------------------------
// bmm_datapath
// Adjacency rows, search stack, matching state and result register.
// ----------------------------------------------------------------------------
module bmm_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  bmm_pkg::req_type       req_data,
   input  logic                   csr_valid,
   input  logic [4:0]             csr_data,
   input  logic                   rsp_stall,
   input  bmm_pkg::dp_cmd_type    cmd,
   output bmm_pkg::dp_status_type status,
   output logic                   rsp_valid,
   output bmm_pkg::rsp_type       rsp_data
);

   logic [15:0] adj_ff [16];
   logic [3:0]  partner_ff [16];
   logic [3:0]  stack_vertex_ff [16];
   logic [4:0]  stack_next_ff [16];
   logic [15:0] taken_ff;
   logic [15:0] visited_ff;
   logic [4:0]  depth_ff;
   logic [4:0]  size_ff;
   logic [4:0]  active_ff;
   logic [4:0]  n_ff;
   logic [3:0]  u_ff;
   logic [3:0]  emit_idx_ff;
   logic        rsp_valid_ff;
   bmm_pkg::rsp_type rsp_ff;

   logic [4:0]  n_sat;
   logic [4:0]  depth_dec;
   logic [3:0]  top_idx;
   logic [3:0]  cur_v;
   logic [4:0]  cur_next;
   logic [15:0] cur_row;
   logic [15:0] cand;
   logic [3:0]  hit_idx;
   logic        found;
   logic [3:0]  rd_addr;
   logic [3:0]  part_rd;
   logic [4:0]  commit_r;
   logic [4:0]  n_dec;
   logic        row_ok;

   always_comb begin
      if (active_ff == 5'd0) begin
         n_sat = 5'd1;
      end else if (active_ff > bmm_pkg::SIDE_CAP_W) begin
         n_sat = bmm_pkg::SIDE_CAP_W;
      end else begin
         n_sat = active_ff;
      end
   end

   assign row_ok    = ({1'b0, req_data.left_vertex} < bmm_pkg::SIDE_CAP_W);
   assign depth_dec = depth_ff - 5'd1;
   assign top_idx   = depth_dec[3:0];
   assign cur_v     = stack_vertex_ff[top_idx];
   assign cur_next  = stack_next_ff[top_idx];
   assign cur_row   = adj_ff[cur_v];
   assign commit_r  = cur_next - 5'd1;
   assign n_dec     = n_ff - 5'd1;

   // Candidates: neighbour, not visited, active, at or past the resume index.
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         cand[i] = cur_row[i] & ~visited_ff[i] & (5'(i) < n_ff) & (5'(i) >= cur_next);
      end
      hit_idx = 4'd0;
      for (int i = 15; i >= 0; i--) begin
         if (cand[i]) begin
            hit_idx = 4'(i);
         end
      end
      found = |cand;
   end

   assign rd_addr = cmd.emit ? emit_idx_ff : hit_idx;
   assign part_rd = partner_ff[rd_addr];

   assign status.dead_end  = ~found;
   assign status.free_hit  = found & ~taken_ff[hit_idx];
   assign status.depth_one = (depth_ff == 5'd1);
   assign status.last_u    = ({1'b0, u_ff} == n_dec);
   assign status.last_emit = ({1'b0, emit_idx_ff} == n_dec);
   assign status.out_free  = ~rsp_valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.load && row_ok) begin
         adj_ff[req_data.left_vertex] <= req_data.neighbours;
      end
      if (cmd.begin_match) begin
         n_ff <= n_sat;
      end
      if (cmd.init_try) begin
         stack_vertex_ff[0] <= u_ff;
         stack_next_ff[0]   <= 5'd0;
      end
      if (cmd.step && found) begin
         stack_next_ff[top_idx] <= {1'b0, hit_idx} + 5'd1;
         if (taken_ff[hit_idx] && depth_ff != bmm_pkg::DEPTH_MAX_W) begin
            stack_vertex_ff[depth_ff[3:0]] <= part_rd;
            stack_next_ff[depth_ff[3:0]]   <= 5'd0;
         end
      end
      if (cmd.commit) begin
         partner_ff[commit_r[3:0]] <= cur_v;
      end
      if (cmd.emit) begin
         rsp_ff.right_vertex  <= emit_idx_ff;
         rsp_ff.owner         <= taken_ff[emit_idx_ff] ? part_rd : 4'd0;
         rsp_ff.is_matched    <= taken_ff[emit_idx_ff];
         rsp_ff.matching_size <= size_ff;
         rsp_ff.last          <= status.last_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= bmm_pkg::ACTIVE_RESET;
         taken_ff     <= '0;
         visited_ff   <= '0;
         depth_ff     <= 5'd0;
         size_ff      <= 5'd0;
         u_ff         <= 4'd0;
         emit_idx_ff  <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            active_ff <= csr_data;
         end
         if (cmd.begin_match) begin
            taken_ff <= '0;
            size_ff  <= 5'd0;
            u_ff     <= 4'd0;
         end
         if (cmd.init_try) begin
            visited_ff <= '0;
            depth_ff   <= 5'd1;
         end
         if (cmd.step) begin
            if (found) begin
               visited_ff[hit_idx] <= 1'b1;
               if (!taken_ff[hit_idx]) begin
                  size_ff <= size_ff + 5'd1;
               end else if (depth_ff != bmm_pkg::DEPTH_MAX_W) begin
                  depth_ff <= depth_ff + 5'd1;
               end
            end else begin
               // Dead end: drop the frame.
               depth_ff <= depth_dec;
            end
         end
         if (cmd.commit) begin
            taken_ff[commit_r[3:0]] <= 1'b1;
            depth_ff <= depth_dec;
         end
         if (cmd.next_u) begin
            u_ff <= u_ff + 4'd1;
         end
         if (cmd.emit_init) begin
            emit_idx_ff <= 4'd0;
         end
         if (cmd.emit) begin
            emit_idx_ff  <= emit_idx_ff + 4'd1;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      depth_ff <= bmm_pkg::DEPTH_MAX_W)
      else $error("search stack overflow");

   assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> depth_ff != 5'd0)
      else $error("search step on empty stack");

   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> cur_next != 5'd0)
      else $error("commit of a frame with no chosen right vertex");

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> $countones(taken_ff) == 32'(size_ff))
      else $error("matching size disagrees with taken right vertices");
`endif

endmodule

>>> sim/tb_bipartite_max_matching_top.sv
// ----------------------------------------------------------------------------
// tb_bipartite_max_matching_top
// Self-checking bench for the bipartite maximum matching block. Graph rows are
// streamed in with bursty valid, the vertex count is changed between phases,
// and every right-vertex report is compared against a matching computed here
// by an augmenting-path search over a private copy of the adjacency rows.
// ----------------------------------------------------------------------------
module tb_bipartite_max_matching_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIRECTED_ROWS = 22;
   localparam int RANDOM_ROWS   = 76;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 600;
   localparam int CYCLE_LIMIT   = 1000000;

   // Tracks the graph as the block sees it and holds the reports it owes.
   class match_board;
      logic [15:0] adj_rows [bmm_pkg::SIDE_MAX];
      logic [3:0]  owner_of [bmm_pkg::SIDE_MAX];
      logic [15:0] taken;
      logic [15:0] seen;
      logic [4:0]  active_count;
      bmm_pkg::rsp_type owed_reports [$];
      int          errors;
      int          reports_checked;
      int          graphs_matched;
      logic [16:0] sizes_covered;

      function new();
         active_count  = bmm_pkg::ACTIVE_RESET;
         errors        = 0;
         reports_checked = 0;
         graphs_matched  = 0;
         sizes_covered   = '0;
         taken = '0;
         seen  = '0;
         foreach (adj_rows[i]) adj_rows[i] = '0;
         foreach (owner_of[i]) owner_of[i] = '0;
      endfunction

      function int side_count();
         if (active_count == 0) return 1;
         if (int'(active_count) > bmm_pkg::SIDE_CAP) return bmm_pkg::SIDE_CAP;
         return int'(active_count);
      endfunction

      // Depth-first search for an augmenting path from one left vertex.
      function void augment_from(int start, int n);
         int frame_left [bmm_pkg::SIDE_MAX];
         int frame_next [bmm_pkg::SIDE_MAX];
         int depth;
         int top;
         int v;
         int j;
         int r;
         bit found;
         seen = '0;
         depth = 1;
         frame_left[0] = start;
         frame_next[0] = 0;
         while (depth > 0) begin
            top = depth - 1;
            v = frame_left[top];
            j = frame_next[top];
            found = 1'b0;
            while (j < n && !found) begin
               if (!seen[j] && adj_rows[v][j]) begin
                  seen[j] = 1'b1;
                  frame_next[top] = j + 1;
                  found = 1'b1;
               end else begin
                  j++;
               end
            end
            if (!found) begin
               depth--;
            end else if (!taken[j]) begin
               // flip the whole path: each frame keeps the right vertex it chose
               for (int k = 0; k < depth; k++) begin
                  r = frame_next[k] - 1;
                  owner_of[r] = 4'(frame_left[k]);
                  taken[r] = 1'b1;
               end
               return;
            end else if (depth < bmm_pkg::SIDE_MAX) begin
               frame_left[depth] = int'(owner_of[j]);
               frame_next[depth] = 0;
               depth++;
            end
         end
      endfunction

      function void note_request(bmm_pkg::req_type item);
         int n;
         int pairs;
         bmm_pkg::rsp_type report;
         adj_rows[item.left_vertex] = item.neighbours;
         if (!item.last_row) return;
         n = side_count();
         foreach (owner_of[i]) owner_of[i] = '0;
         taken = '0;
         for (int u = 0; u < n; u++) augment_from(u, n);
         pairs = $countones(taken);
         sizes_covered[pairs] = 1'b1;
         graphs_matched++;
         for (int j = 0; j < n; j++) begin
            report.right_vertex  = 4'(j);
            report.owner         = taken[j] ? owner_of[j] : 4'd0;
            report.is_matched    = taken[j];
            report.matching_size = 5'(pairs);
            report.last          = (j == n - 1);
            owed_reports.insert(owed_reports.size(), report);
         end
      endfunction

      function void flag(string field, int want, logic [4:0] got);
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      endfunction

      function void check_result(bmm_pkg::rsp_type got);
         bmm_pkg::rsp_type want;
         if (owed_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected report, expected none, actual %p", $time, got);
            return;
         end
         want = owed_reports.pop_front();
         reports_checked++;
         if (got.right_vertex !== want.right_vertex)
            flag("right_vertex", want.right_vertex, got.right_vertex);
         if (got.owner !== want.owner)
            flag("owner", want.owner, got.owner);
         if (got.is_matched !== want.is_matched)
            flag("is_matched", want.is_matched, got.is_matched);
         if (got.matching_size !== want.matching_size)
            flag("matching_size", want.matching_size, got.matching_size);
         if (got.last !== want.last)
            flag("last", want.last, got.last);
      endfunction

      function int outstanding();
         return owed_reports.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   bmm_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   bmm_pkg::rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [4:0] csr_data;

   match_board board = new();
   int  cycle_count = 0;
   int  rows_sent   = 0;
   int  burst_left  = 0;
   bit  hold_armed  = 1'b0;
   bit  hold_done   = 1'b0;
   logic [16:0] counts_covered = '0;

   bipartite_max_matching_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Result side: random stall pattern plus one long hold-off.
   initial begin : receiver
      int pattern_left;
      int stall_pct;
      pattern_left = 0;
      stall_pct = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
         if (hold_armed && !hold_done && rsp_valid) begin
            // hold the block full while rows keep arriving
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(20, 80);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 25;
               2: stall_pct = 50;
               default: stall_pct = 90;
            endcase
         end
         pattern_left--;
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   function automatic int pick_burst();
      if ($urandom_range(0, 3) == 0) return $urandom_range(40, 80);
      return $urandom_range(1, 8);
   endfunction

   function automatic logic [15:0] random_mask();
      case ($urandom_range(0, 5))
         0: return 16'($urandom & $urandom);
         1: return 16'($urandom | $urandom);
         2: return 16'($urandom);
         3: return 16'h0001 << $urandom_range(0, 15);
         4: return 16'hFFFF;
         default: return 16'($urandom & $urandom & $urandom);
      endcase
   endfunction

   task automatic send_row(input logic [3:0] vertex, input logic [15:0] mask,
                           input logic last);
      bmm_pkg::req_type item;
      item = '{left_vertex: vertex, neighbours: mask, last_row: last};
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = pick_burst();
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(item);
      burst_left--;
      rows_sent++;
   endtask

   task automatic write_vertex_count(input logic [4:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.active_count = value;
      counts_covered[board.side_count()] = 1'b1;
   endtask

   // Drop valid, let every owed report drain, then give the block time to settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_graph();
      int n;
      int order [$];
      n = board.side_count();
      if ($urandom_range(0, 3) != 0) begin
         for (int k = 0; k < n; k++) order.insert(order.size(), k);
         order.shuffle();
         // extra rows ahead of the closing one, any index
         repeat ($urandom_range(0, 2))
            order.insert($urandom_range(0, order.size() - 1), $urandom_range(0, 15));
      end else begin
         // rows persist: touch only a few and rematch
         repeat ($urandom_range(1, 3)) order.insert(order.size(), $urandom_range(0, 15));
      end
      foreach (order[k])
         send_row(4'(order[k]), random_mask(), k == order.size() - 1);
   endtask

   initial begin : stimulus
      int graphs;
      bit first_phase;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      counts_covered[board.side_count()] = 1'b1;

      // Shifting chain: the last vertex forces an augmenting path through all.
      send_row(4'd15, 16'h0001, 1'b0);
      for (int u = 0; u < 15; u++)
         send_row(4'(u), (16'h0001 << u) | (16'h0001 << (u + 1)), u == 14);
      send_row(4'd3, 16'h0000, 1'b0);
      send_row(4'd7, 16'hFFFF, 1'b1);
      wait_idle();

      // Zero count acts as one; neighbour bits above it are ignored.
      write_vertex_count(5'd0);
      send_row(4'd0, 16'hFFFE, 1'b1);
      send_row(4'd0, 16'h0000, 1'b1);
      wait_idle();
      write_vertex_count(5'd1);
      send_row(4'd0, 16'h0001, 1'b1);
      wait_idle();
      // Count above the side limit saturates.
      write_vertex_count(5'd31);
      send_row(4'd15, 16'hFFFF, 1'b1);
      wait_idle();

      first_phase = 1'b1;
      while (rows_sent < DIRECTED_ROWS + RANDOM_ROWS) begin
         if (first_phase) begin
            write_vertex_count(5'd16);
            hold_armed = 1'b1;
            graphs = 3;
         end else begin
            case ($urandom_range(0, 6))
               0: write_vertex_count(5'd0);
               1: write_vertex_count(5'd1);
               2: write_vertex_count(5'd31);
               3: write_vertex_count(5'd16);
               default: write_vertex_count(5'($urandom_range(0, 31)));
            endcase
            graphs = $urandom_range(1, 2);
         end
         first_phase = 1'b0;
         repeat (graphs) send_graph();
         wait_idle();
      end

      $display("Sent %0d rows forming %0d graphs; checked %0d right-vertex reports.",
               rows_sent, board.graphs_matched, board.reports_checked);
      $display("Vertex counts covered %b, matching sizes covered %b.",
               counts_covered, board.sizes_covered);
      if (board.errors == 0 && board.outstanding() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> bipartite_max_matching_top.f
design/bmm_pkg.sv
design/bmm_controller.sv
design/bmm_datapath.sv
design/bipartite_max_matching_top.sv
sim/tb_bipartite_max_matching_top.sv
